// ----- design/pcf_pkg.sv -----
// Shared types, constants and a helper function for the pitch complementary filter.
package pcf_pkg;

  localparam int CalSamplesDefault = 200;
  localparam int CordicSteps = 16;
  localparam logic [31:0] Deg2RadQ32 = 32'd74961321;
  localparam logic signed [19:0] PiQ16 = 20'sd205887;
  localparam logic [15:0] BlendGainReset = 16'd64225;
  localparam logic [15:0] StepTimeReset = 16'd1260;
  localparam int QueueDepth = 2;

  typedef enum logic [0:0] {
    REG_BLEND_GAIN = 1'b0,
    REG_STEP_TIME  = 1'b1
  } reg_index_t;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    logic               calibrate;
    logic signed [16:0] acc_y;
    logic signed [15:0] acc_x;
    logic signed [15:0] gyro_rate;
    logic signed [15:0] offset;
  } work_t;

  // arctangent table, Q.16 radians
  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    logic signed [19:0] r;
    unique case (i)
      4'd0:    r = 20'sd51472;
      4'd1:    r = 20'sd30386;
      4'd2:    r = 20'sd16055;
      4'd3:    r = 20'sd8150;
      4'd4:    r = 20'sd4091;
      4'd5:    r = 20'sd2047;
      4'd6:    r = 20'sd1024;
      4'd7:    r = 20'sd512;
      4'd8:    r = 20'sd256;
      4'd9:    r = 20'sd128;
      4'd10:   r = 20'sd64;
      4'd11:   r = 20'sd32;
      4'd12:   r = 20'sd16;
      4'd13:   r = 20'sd8;
      4'd14:   r = 20'sd4;
      default: r = 20'sd2;
    endcase
    return r;
  endfunction

endpackage

// ----- design/pcf_front.sv -----
// Front end: takes IMU samples, handles calibration, queues filter work.
module pcf_front #(
  parameter int CAL_SAMPLES = pcf_pkg::CalSamplesDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  calibrate,
  input  logic signed [15:0]    accel_x,
  input  logic signed [15:0]    accel_z,
  input  logic signed [15:0]    gyro_rate,
  output logic                  q_valid,
  output pcf_pkg::work_t        q_item,
  output logic                  q_done,
  input  logic                  q_take
);
  import pcf_pkg::*;

  localparam int CntW = $clog2(CAL_SAMPLES + 1);
  // quotient of sum/CAL_SAMPLES via reciprocal: sum*2+n over 2n
  localparam int RecShift = 40;
  localparam logic [40:0] Recip =
    41'((64'd1 << RecShift) / (2 * CAL_SAMPLES) + 1);

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_DIV  = 3'b010,
    S_FIX  = 3'b100
  } fstate_t;

  fstate_t state;
  logic signed [23:0] sum;
  logic [CntW-1:0] count;
  logic signed [15:0] x_offset;
  logic signed [15:0] fix_off;
  logic [25:0] mag;
  logic neg;
  logic [66:0] prod;
  logic [25:0] quo;

  // two-entry queue
  work_t q_mem [QueueDepth];
  logic  q_dn  [QueueDepth];
  logic  wptr, rptr;
  logic [1:0] fill;
  logic enq, enq_done;
  work_t enq_item;

  logic accept;
  assign full = (state != S_RUN) || (fill == 2'(QueueDepth));
  assign accept = push && !full;
  assign q_valid = (fill != 2'd0);
  assign q_item = q_mem[rptr];
  assign q_done = q_dn[rptr];

  logic signed [23:0] sum_next;
  logic signed [16:0] diff;
  assign sum_next = sum + 24'(accel_x);
  assign diff = 17'(x_offset) - 17'(accel_x);

  // rounded mean, saturated to 16 bits
  always_comb begin
    if (neg) begin
      fix_off = ($signed({1'b0, quo}) > 27'sd32768) ? -16'sd32768
                : 16'(-$signed({1'b0, quo}));
    end else begin
      fix_off = (quo > 26'd32767) ? 16'sd32767 : 16'(quo);
    end
  end

  always_comb begin
    enq = 1'b0;
    enq_done = 1'b0;
    enq_item = '0;
    enq_item.calibrate = calibrate;
    enq_item.acc_y = diff;
    enq_item.acc_x = accel_z;
    enq_item.gyro_rate = gyro_rate;
    enq_item.offset = x_offset;
    if (accept && !(calibrate && (count == CntW'(CAL_SAMPLES - 1)))) begin
      enq = 1'b1;
    end
    if (state == S_FIX) begin
      enq = 1'b1;
      enq_done = 1'b1;
      enq_item.calibrate = 1'b1;
      enq_item.offset = fix_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      sum <= '0;
      count <= '0;
      x_offset <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      unique case (state)
        S_RUN: begin
          if (accept && calibrate) begin
            if (count == CntW'(CAL_SAMPLES - 1)) begin
              mag <= sum_next[23] ? 26'(-sum_next) * 2 + 26'(CAL_SAMPLES)
                                  : 26'(sum_next) * 2 + 26'(CAL_SAMPLES);
              neg <= sum_next[23];
              sum <= '0;
              count <= '0;
              state <= S_DIV;
            end else begin
              sum <= sum_next;
              count <= count + 1'b1;
            end
          end
        end
        S_DIV: begin
          prod <= 67'(mag) * 67'(Recip);
          state <= S_FIX;
        end
        S_FIX: begin
          x_offset <= fix_off;
          state <= S_RUN;
        end
        default: state <= S_RUN;
      endcase
      if (enq) begin
        wptr <= ~wptr;
      end
      if (q_take) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, enq} - {1'b0, q_take};
    end
  end

  // quotient correction: reciprocal may overshoot by one
  logic [25:0] qraw;
  logic [26:0] chk;
  assign qraw = prod[RecShift +: 26];
  assign chk = 27'(qraw) * 27'(2 * CAL_SAMPLES);
  assign quo = (chk > 27'(mag)) ? qraw - 1'b1 : qraw;

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wptr] <= enq_item;
      q_dn[wptr] <= enq_done;
    end
  end

endmodule

// ----- design/pcf_back.sv -----
// Back end: gyro integration, CORDIC atan2, blend and result register.
module pcf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  pcf_pkg::work_t      q_item,
  input  logic                q_done,
  output logic                q_take,
  input  logic [15:0]         blend_gain,
  input  logic [15:0]         step_time,
  output logic                empty,
  input  logic                pop,
  output logic signed [15:0]  pitch,
  output logic signed [15:0]  accel_offset,
  output logic                calibration_done
);
  import pcf_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_MUL1  = 6'b000010,
    B_CORD  = 6'b000100,
    B_MUL2  = 6'b001000,
    B_BLEND = 6'b010000,
    B_OUT   = 6'b100000
  } bstate_t;

  bstate_t state;
  work_t item;
  logic done;
  logic signed [31:0] gprod;
  logic signed [63:0] dprod;
  logic signed [26:0] cx, cy;
  logic signed [19:0] cz;
  logic [3:0] step;
  logic signed [15:0] pest;
  logic signed [48:0] mix_a, mix_b;
  logic out_full;
  logic out_load;

  assign q_take = (state == B_IDLE) && q_valid;
  assign empty = !out_full;
  assign out_load = (state == B_OUT) && (!out_full || pop);

  logic signed [26:0] dx, dy;
  assign dx = cy >>> step;
  assign dy = cx >>> step;

  logic signed [32:0] delta;
  logic [63:0] dmag;
  logic signed [32:0] est;
  logic signed [17:0] acc;
  logic [20:0] zmag;
  logic signed [49:0] mix;
  logic [49:0] mmag;
  logic signed [34:0] blended;

  always_comb begin
    dmag = dprod[63] ? 64'(-dprod) : 64'(dprod);
    delta = dprod[63] ? -$signed({1'b0, 32'((dmag + (64'd1 << 40)) >> 41)})
                      : $signed({1'b0, 32'((dmag + (64'd1 << 40)) >> 41)});
    est = 33'(pest) + delta;
    zmag = cz[19] ? 21'(-cz) : 21'(cz);
    acc = cz[19] ? -$signed({1'b0, 17'((zmag + 21'd4) >> 3)})
                 : $signed({1'b0, 17'((zmag + 21'd4) >> 3)});
    mix = 50'(mix_a) + 50'(mix_b);
    mmag = mix[49] ? 50'(-mix) : 50'(mix);
    blended = mix[49] ? -$signed({1'b0, 34'((mmag + 50'd32768) >> 16)})
                      : $signed({1'b0, 34'((mmag + 50'd32768) >> 16)});
  end

  logic zero_in;
  assign zero_in = (q_item.acc_y == 17'sd0) && (q_item.acc_x == 16'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_full <= 1'b0;
      pest <= '0;
    end else begin
      if (out_load) begin
        out_full <= 1'b1;
      end else if (pop && out_full) begin
        out_full <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            item <= q_item;
            done <= q_done;
            if (q_item.calibrate) begin
              state <= B_OUT;
            end else begin
              gprod <= 32'(q_item.gyro_rate) * $signed({1'b0, step_time});
              step <= '0;
              if (zero_in) begin
                cx <= '0;
                cy <= '0;
                cz <= '0;
                state <= B_MUL1;
              end else if (q_item.acc_x < 0) begin
                cx <= -(27'(q_item.acc_x) <<< 8);
                cy <= -(27'(q_item.acc_y) <<< 8);
                cz <= (q_item.acc_y >= 0) ? PiQ16 : -PiQ16;
                state <= B_MUL1;
              end else begin
                cx <= 27'(q_item.acc_x) <<< 8;
                cy <= 27'(q_item.acc_y) <<< 8;
                cz <= '0;
                state <= B_MUL1;
              end
            end
          end
        end
        B_MUL1: begin
          dprod <= 64'(gprod) * $signed({1'b0, Deg2RadQ32});
          state <= (item.acc_y == 17'sd0 && item.acc_x == 16'sd0) ? B_MUL2 : B_CORD;
        end
        B_CORD: begin
          if (cy >= 0) begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + atan_q16(step);
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - atan_q16(step);
          end
          step <= step + 1'b1;
          if (step == 4'(CordicSteps - 1)) begin
            state <= B_MUL2;
          end
        end
        B_MUL2: begin
          mix_a <= 49'(est) * $signed({1'b0, blend_gain});
          mix_b <= 49'(acc) * $signed(18'(18'd65536 - {2'b0, blend_gain}));
          state <= B_BLEND;
        end
        B_BLEND: begin
          pest <= (blended > 35'sd32767) ? 16'sd32767
                : (blended < -35'sd32768) ? -16'sd32768 : 16'(blended);
          state <= B_OUT;
        end
        B_OUT: begin
          if (out_load) begin
            pitch <= pest;
            accel_offset <= item.offset;
            calibration_done <= done;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- design/pitch_complementary_filter_unit.sv -----
// Top level of the pitch complementary filter.
// Takes one IMU sample per push and gives one result per sample. A filter
// sample passes through the back end's 16-step iterative CORDIC, the two
// multiply stages, the blend and the result load (the CORDIC is skipped
// when both accel operands are zero); a calibration sample goes straight
// to the result load, and the one that closes a window first waits for
// the mean (reciprocal multiply and correction). A two-entry queue sits
// between the calibration front end and the filter back end, and a result
// register holds the finished item until it is popped.
module pitch_complementary_filter_unit #(
  parameter int CAL_SAMPLES = pcf_pkg::CalSamplesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               calibrate,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_rate,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] pitch,
  output logic signed [15:0] accel_offset,
  output logic               calibration_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import pcf_pkg::*;

  logic [15:0] blend_gain, step_time;
  logic q_valid, q_done, q_take;
  work_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_gain <= BlendGainReset;
      step_time <= StepTimeReset;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_BLEND_GAIN: blend_gain <= cfg_data;
        REG_STEP_TIME:  step_time <= cfg_data;
        default: ;
      endcase
    end
  end

  pcf_front #(.CAL_SAMPLES(CAL_SAMPLES)) u_front (
    .clk, .rst, .push, .full, .calibrate, .accel_x, .accel_z, .gyro_rate,
    .q_valid, .q_item, .q_done, .q_take
  );

  pcf_back u_back (
    .clk, .rst, .q_valid, .q_item, .q_done, .q_take, .blend_gain, .step_time,
    .empty, .pop, .pitch, .accel_offset, .calibration_done
  );

endmodule
